@@ design/srtt_pkg.sv @@
// Shared types and constants for the scaled RTP timestamp tracker.
// Holds the mode codes, configuration indexes and the structs between modules.
// No dependencies.
package srtt_pkg;

    localparam int unsigned TS_W     = 32;
    localparam int unsigned SN_W     = 16;
    localparam int unsigned STRIDE_W = 29;
    localparam int unsigned REP_W    = 4;
    localparam int unsigned IN_W     = 48;
    localparam int unsigned OUT_W    = 96;

    // tracking modes, as reported on the output
    typedef enum logic [1:0] {
        MODE_INIT   = 2'd0,
        MODE_LEARN  = 2'd1,
        MODE_SCALED = 2'd2
    } t_mode;

    // configuration register indexes
    localparam logic CFG_MAX_STRIDE = 1'b0;
    localparam logic CFG_REPEAT_MIN = 1'b1;

    localparam logic [STRIDE_W-1:0] MAX_STRIDE_RST = {STRIDE_W{1'b1}};
    localparam logic [REP_W-1:0]    REPEAT_MIN_RST = 4'd3;
    localparam logic [REP_W-1:0]    REP_SAT        = {REP_W{1'b1}};

    // divider request and response
    typedef struct packed {
        logic                start;
        logic [TS_W-1:0]     dividend;
        logic [STRIDE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [TS_W-1:0]     quot;
        logic [STRIDE_W-1:0] rem;
    } t_div_rsp;

    // one result word
    typedef struct packed {
        logic                deducible;
        logic [TS_W-1:0]     scaled;
        logic [STRIDE_W-1:0] offset;
        logic [STRIDE_W-1:0] stride;
        t_mode               mode;
    } t_result;

endpackage

@@ design/srtt_div.sv @@
// Radix-2 restoring divider, 32-bit dividend by 29-bit divisor, one bit a cycle.
// Shared by both divisions of a packet. Depends on srtt_pkg.
module srtt_div
    import srtt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [4:0]          r_cnt, n_cnt;
    logic [TS_W-1:0]     r_dvd, n_dvd;
    logic [STRIDE_W-1:0] r_rem, n_rem;
    logic [STRIDE_W-1:0] r_dsr, n_dsr;

    logic [STRIDE_W:0]   w_trial;
    logic [STRIDE_W:0]   w_diff;
    logic                w_fits;

    // one shift-subtract step
    assign w_trial = {r_rem, r_dvd[TS_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_req.dividend;
            n_rem  = '0;
            n_dsr  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = w_fits ? w_diff[STRIDE_W-1:0] : w_trial[STRIDE_W-1:0];
            n_dvd = {r_dvd[TS_W-2:0], w_fits};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dvd;
    assign o_rsp.rem  = r_rem;

endmodule

@@ design/srtt_ctrl.sv @@
// Sequencer and tracking state: deltas, mode changes and result register.
// Drives the shared divider. Depends on srtt_pkg.
module srtt_ctrl
    import srtt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [TS_W-1:0]     i_ts,
    input  logic [SN_W-1:0]     i_sn,
    input  logic [STRIDE_W-1:0] i_max_stride,
    input  logic [REP_W-1:0]    i_rep_min,
    output t_div_req            o_div_req,
    input  t_div_rsp            i_div_rsp,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_result             o_out
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DELTA = 5'b00010,
        S_DIV1  = 5'b00100,
        S_DIV2  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [TS_W-1:0]     r_ts, n_ts;
    logic [SN_W-1:0]     r_sn, n_sn;
    logic [TS_W-1:0]     r_prev_ts, n_prev_ts;
    logic [SN_W-1:0]     r_prev_sn, n_prev_sn;
    logic                r_have_prev, n_have_prev;
    logic [STRIDE_W-1:0] r_stride, n_stride;
    logic [STRIDE_W-1:0] r_offset, n_offset;
    logic [TS_W-1:0]     r_scaled, n_scaled;
    t_mode               r_mode, n_mode;
    logic [REP_W-1:0]    r_rep, n_rep;
    logic                r_ded, n_ded;
    logic [STRIDE_W-1:0] r_ts_delta, n_ts_delta;
    logic [SN_W-1:0]     r_sn_delta, n_sn_delta;
    logic                r_learn, n_learn;
    t_result             r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic [TS_W-1:0]     w_ts_delta;
    logic [SN_W-1:0]     w_sn_delta;
    logic [REP_W-1:0]    w_rep_base;
    logic [REP_W-1:0]    w_rep_inc;
    logic [STRIDE_W-1:0] w_off;
    logic [TS_W-1:0]     w_sc;
    logic [TS_W-1:0]     w_sc_up;
    logic [TS_W-1:0]     w_sc_down;

    // absolute deltas against the previous packet
    assign w_ts_delta = (r_ts >= r_prev_ts) ? (r_ts - r_prev_ts) : (r_prev_ts - r_ts);
    assign w_sn_delta = (r_sn >= r_prev_sn) ? (r_sn - r_prev_sn) : (r_prev_sn - r_sn);

    // repeat counter on the learning path
    assign w_rep_base = ((r_ts_delta != r_stride) || (i_div_rsp.rem != r_offset)) ?
                        '0 : r_rep;
    assign w_rep_inc  = (w_rep_base == REP_SAT) ? REP_SAT : (w_rep_base + 4'd1);

    // offset and scaled value on the scaled path; zero stride gives zeros
    assign w_off     = (r_stride == '0) ? '0 : i_div_rsp.rem;
    assign w_sc      = (r_stride == '0) ? '0 : i_div_rsp.quot;
    assign w_sc_up   = w_sc - r_scaled;
    assign w_sc_down = r_scaled - w_sc;

    always_comb begin
        n_state     = r_state;
        n_ts        = r_ts;
        n_sn        = r_sn;
        n_prev_ts   = r_prev_ts;
        n_prev_sn   = r_prev_sn;
        n_have_prev = r_have_prev;
        n_stride    = r_stride;
        n_offset    = r_offset;
        n_scaled    = r_scaled;
        n_mode      = r_mode;
        n_rep       = r_rep;
        n_ded       = r_ded;
        n_ts_delta  = r_ts_delta;
        n_sn_delta  = r_sn_delta;
        n_learn     = r_learn;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = r_ts;
        o_div_req.divisor  = r_stride;

        // result word taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_ts    = i_ts;
                    n_sn    = i_sn;
                    n_state = S_DELTA;
                end
            end
            // classify the packet and, unless it goes straight to the output, launch the first division
            S_DELTA: begin
                n_ded      = 1'b0;
                n_ts_delta = w_ts_delta[STRIDE_W-1:0];
                n_sn_delta = w_sn_delta;
                if (!r_have_prev) begin
                    n_have_prev = 1'b1;
                    n_state     = S_OUT;
                end else if ((w_ts_delta == '0) ||
                             (w_ts_delta > {3'b000, i_max_stride})) begin
                    n_mode  = MODE_INIT;
                    n_state = S_OUT;
                end else if (r_mode == MODE_SCALED) begin
                    n_learn = 1'b0;
                    o_div_req.start = 1'b1;
                    if (w_ts_delta[STRIDE_W-1:0] != r_stride) begin
                        if (r_stride == '0) begin
                            n_mode   = MODE_LEARN;
                            n_rep    = '0;
                            n_stride = w_ts_delta[STRIDE_W-1:0];
                            o_div_req.divisor = w_ts_delta[STRIDE_W-1:0];
                            n_state  = S_DIV2;
                        end else begin
                            o_div_req.dividend = w_ts_delta;
                            n_state = S_DIV1;
                        end
                    end else begin
                        n_state = S_DIV2;
                    end
                end else begin
                    n_learn = 1'b1;
                    if (r_mode != MODE_LEARN) begin
                        n_rep = '0;
                    end
                    n_mode = MODE_LEARN;
                    o_div_req.start   = 1'b1;
                    o_div_req.divisor = w_ts_delta[STRIDE_W-1:0];
                    n_state = S_DIV2;
                end
            end
            // delta against stride: not a multiple, or a jump
            S_DIV1: begin
                if (i_div_rsp.done) begin
                    o_div_req.start = 1'b1;
                    if (i_div_rsp.rem != '0) begin
                        n_mode   = MODE_LEARN;
                        n_rep    = '0;
                        n_stride = r_ts_delta;
                        o_div_req.divisor = r_ts_delta;
                    end else if (i_div_rsp.quot != {16'h0000, r_sn_delta}) begin
                        n_mode = MODE_LEARN;
                        n_rep  = '0;
                    end
                    n_state = S_DIV2;
                end
            end
            // timestamp by stride: offset and scaled value
            S_DIV2: begin
                if (i_div_rsp.done) begin
                    if (r_learn) begin
                        n_stride = r_ts_delta;
                        n_offset = i_div_rsp.rem;
                        n_scaled = i_div_rsp.quot;
                        n_rep    = w_rep_inc;
                        if (w_rep_inc >= i_rep_min) begin
                            n_mode = MODE_SCALED;
                        end
                    end else begin
                        n_offset = w_off;
                        n_scaled = w_sc;
                        if (r_mode == MODE_SCALED) begin
                            if (w_sc >= r_scaled) begin
                                n_ded = (r_sn >= r_prev_sn) &&
                                        (w_sc_up == {16'h0000, r_sn_delta});
                            end else begin
                                n_ded = (r_prev_sn >= r_sn) &&
                                        (w_sc_down == {16'h0000, r_sn_delta});
                            end
                        end
                        // timestamp below the previous one with a moved offset
                        if ((r_ts < r_prev_ts) && (r_offset != w_off)) begin
                            n_mode = MODE_LEARN;
                            n_rep  = '0;
                        end
                    end
                    n_state = S_OUT;
                end
            end
            // hand the word to the output register
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.mode      = r_mode;
                    n_out.stride    = r_stride;
                    n_out.offset    = r_offset;
                    n_out.scaled    = r_scaled;
                    n_out.deducible = r_ded;
                    n_out_valid     = 1'b1;
                    n_prev_ts       = r_ts;
                    n_prev_sn       = r_sn;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_ts   <= '0;
            r_prev_sn   <= '0;
            r_have_prev <= 1'b0;
            r_stride    <= '0;
            r_offset    <= '0;
            r_scaled    <= '0;
            r_mode      <= MODE_INIT;
            r_rep       <= '0;
            r_ded       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev_ts   <= n_prev_ts;
            r_prev_sn   <= n_prev_sn;
            r_have_prev <= n_have_prev;
            r_stride    <= n_stride;
            r_offset    <= n_offset;
            r_scaled    <= n_scaled;
            r_mode      <= n_mode;
            r_rep       <= n_rep;
            r_ded       <= n_ded;
            r_out_valid <= n_out_valid;
        end
        r_ts       <= n_ts;
        r_sn       <= n_sn;
        r_ts_delta <= n_ts_delta;
        r_sn_delta <= n_sn_delta;
        r_learn    <= n_learn;
        r_out      <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ design/scaled_rtp_timestamp_tracker_unit.sv @@
// Top level of the scaled RTP timestamp tracker: configuration registers,
// sequencer and shared divider. Depends on srtt_pkg, srtt_ctrl, srtt_div.
//
// Usage:
//   s_axis carries one word per packet: RTP timestamp and sequence number.
//   m_axis returns one word per packet: mode, stride, offset, scaled
//   timestamp and the deducible flag, reflecting the state after the packet.
//   The cfg channel writes max_encodable_stride (index 0) and
//   stride_repeat_min (index 1); it is always ready. The user must make sure it
//   is written while idle; the block itself does not enforce this.
// Processing:
//   A first arrival or a zero or out-of-range delta skips the divider; others
//   take one 32-step pass of the radix-2 divider, two if the stride changed
//   while scaled. s_axis_tready is high only while the sequencer waits for a packet.
// Reset:
//   i_rst_n (synchronous, active low) clears the tracking state to the
//   initial mode and restores both configuration registers to their defaults.
// Stall:
//   The result sits in an output register; the next packet is accepted and
//   processed meanwhile, and finishes only once that register is free.
module scaled_rtp_timestamp_tracker_unit
    import srtt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [IN_W-1:0]     s_axis_tdata,  // timestamp[31:0], seq_num[47:32]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata,  // mode[1:0], stride[30:2], offset[59:31],
                                               // scaled[91:60], deducible[92], zero[95:93]
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [STRIDE_W-1:0] i_cfg_data
);

    logic [STRIDE_W-1:0] r_max_stride;
    logic [REP_W-1:0]    r_rep_min;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;
    t_result             w_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_stride <= MAX_STRIDE_RST;
            r_rep_min    <= REPEAT_MIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_STRIDE: r_max_stride <= i_cfg_data;
                CFG_REPEAT_MIN: r_rep_min    <= i_cfg_data[REP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    srtt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_ts         (s_axis_tdata[31:0]),
        .i_sn         (s_axis_tdata[47:32]),
        .i_max_stride (r_max_stride),
        .i_rep_min    (r_rep_min),
        .o_div_req    (w_div_req),
        .i_div_rsp    (w_div_rsp),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out        (w_out)
    );

    srtt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // pack the result word, first field lowest
    assign m_axis_tdata = {3'b000, w_out.deducible, w_out.scaled, w_out.offset,
                           w_out.stride, w_out.mode};

endmodule

@@ design/srtt_checker.sv @@
// Port-level checks for the scaled RTP timestamp tracker, with its bind.
// Depends on srtt_pkg and scaled_rtp_timestamp_tracker_unit.
module srtt_checker
    import srtt_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // one packet at a time: busy right after a word is taken in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready while a packet is in work");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed under stall");

    // offset is a remainder of the stride
    a_offset_below_stride: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[30:2] != '0)) |->
        (m_axis_tdata[59:31] < m_axis_tdata[30:2]))
        else $error("offset not below stride");

    // the initial mode never reports a deducible value
    a_init_not_deducible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == MODE_INIT)) |-> !m_axis_tdata[92])
        else $error("deducible set in initial mode");

endmodule

bind scaled_rtp_timestamp_tracker_unit srtt_checker u_srtt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ sim/srtt_checker.sv @@
`timescale 1ns / 1ps
// Checker for the scaled RTP timestamp tracker: watches the packet, result and
// configuration channels, predicts each result word and compares it field by field.
// Depends on srtt_pkg.
module srtt_scoreboard
    import srtt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [IN_W-1:0]     i_in_data,   // timestamp[31:0], seq_num[47:32]
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [OUT_W-1:0]    i_out_data,  // mode, stride, offset, scaled, deducible
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [STRIDE_W-1:0] i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    // predicted tracking state
    logic [TS_W-1:0]     last_ts;
    logic [SN_W-1:0]     last_sn;
    logic                seen_first;
    logic [STRIDE_W-1:0] stride_q;
    logic [STRIDE_W-1:0] offset_q;
    logic [TS_W-1:0]     scaled_q;
    t_mode               mode_q;
    logic [REP_W-1:0]    stable_cnt;
    logic                deduce_q;

    // configuration copy
    logic [STRIDE_W-1:0] cfg_max_stride;
    logic [REP_W-1:0]    cfg_repeat_min;

    t_result expected_words[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [TS_W-1:0] got,
                                   input logic [TS_W-1:0] want);
        if (o_fail_count < 100)
            $display("[%0t] srtt mismatch on %s: got %h, expected %h", $time, what, got, want);
        o_fail_count++;
    endtask

    // advance the tracker by one packet and give the word it should report
    function automatic t_result track_packet(input logic [TS_W-1:0] ts,
                                             input logic [SN_W-1:0] sn);
        logic [TS_W-1:0]     old_ts;
        logic [SN_W-1:0]     old_sn;
        logic [SN_W-1:0]     sn_gap;
        logic [TS_W-1:0]     ts_gap;
        logic [TS_W-1:0]     new_off;
        logic [TS_W-1:0]     scaled_before;
        logic [STRIDE_W-1:0] old_off;
        t_result             r;
        old_ts   = last_ts;
        old_sn   = last_sn;
        deduce_q = 1'b0;
        last_ts  = ts;
        last_sn  = sn;
        sn_gap   = (sn >= old_sn) ? sn - old_sn : old_sn - sn;
        ts_gap   = (ts >= old_ts) ? ts - old_ts : old_ts - ts;

        if (!seen_first) begin
            seen_first = 1'b1;
        end else if (ts_gap == 0 || ts_gap > {3'b000, cfg_max_stride}) begin
            mode_q = MODE_INIT;
        end else begin
            if (mode_q != MODE_LEARN && mode_q != MODE_SCALED) begin
                mode_q     = MODE_LEARN;
                stable_cnt = '0;
            end
            if (mode_q == MODE_LEARN) begin
                // relearn: count packets that agree with the stored stride and offset
                new_off = ts % ts_gap;
                if (ts_gap != {3'b000, stride_q} || new_off != {3'b000, offset_q})
                    stable_cnt = '0;
                stride_q = ts_gap[STRIDE_W-1:0];
                offset_q = new_off[STRIDE_W-1:0];
                scaled_q = (ts - new_off) / ts_gap;
                if (stable_cnt != REP_SAT)
                    stable_cnt++;
                if (stable_cnt >= cfg_repeat_min)
                    mode_q = MODE_SCALED;
            end else begin
                scaled_before = scaled_q;
                old_off       = offset_q;
                if (ts_gap != {3'b000, stride_q}) begin
                    if (stride_q == 0 || ts_gap % stride_q != 0) begin
                        // not a multiple: take the new delta as stride
                        mode_q     = MODE_LEARN;
                        stable_cnt = '0;
                        stride_q   = ts_gap[STRIDE_W-1:0];
                    end else if (ts_gap / stride_q != {16'h0000, sn_gap}) begin
                        // multiple, but the sequence number disagrees
                        mode_q     = MODE_LEARN;
                        stable_cnt = '0;
                    end
                end
                if (stride_q == 0) begin
                    offset_q = '0;
                    scaled_q = '0;
                end else begin
                    offset_q = STRIDE_W'(ts % stride_q);
                    scaled_q = (ts - offset_q) / stride_q;
                end
                if (mode_q == MODE_SCALED) begin
                    if (scaled_q >= scaled_before)
                        deduce_q = (sn >= old_sn) && (scaled_q - scaled_before == sn_gap);
                    else
                        deduce_q = (old_sn >= sn) && (scaled_before - scaled_q == sn_gap);
                end
                // timestamp went back and the offset moved
                if (ts < old_ts && old_off != offset_q) begin
                    mode_q     = MODE_LEARN;
                    stable_cnt = '0;
                end
            end
        end

        r.mode      = mode_q;
        r.stride    = stride_q;
        r.offset    = offset_q;
        r.scaled    = scaled_q;
        r.deducible = deduce_q;
        return r;
    endfunction

    // channel monitor
    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            last_ts        = '0;
            last_sn        = '0;
            seen_first     = 1'b0;
            stride_q       = '0;
            offset_q       = '0;
            scaled_q       = '0;
            mode_q         = MODE_INIT;
            stable_cnt     = '0;
            deduce_q       = 1'b0;
            cfg_max_stride = MAX_STRIDE_RST;
            cfg_repeat_min = REPEAT_MIN_RST;
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_MAX_STRIDE)
                    cfg_max_stride = i_cfg_data;
                else if (i_cfg_index == CFG_REPEAT_MIN)
                    cfg_repeat_min = i_cfg_data[REP_W-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", i_out_data[TS_W-1:0], '0);
                end else begin
                    got  = i_out_data[$bits(t_result)-1:0];
                    want = expected_words.pop_front();
                    if (got.mode !== want.mode)
                        report_mismatch("mode", got.mode, want.mode);
                    if (got.stride !== want.stride)
                        report_mismatch("stride", got.stride, want.stride);
                    if (got.offset !== want.offset)
                        report_mismatch("offset", got.offset, want.offset);
                    if (got.scaled !== want.scaled)
                        report_mismatch("scaled", got.scaled, want.scaled);
                    if (got.deducible !== want.deducible)
                        report_mismatch("deducible", got.deducible, want.deducible);
                    if (i_out_data[OUT_W-1:$bits(t_result)] !== '0)
                        report_mismatch("padding", i_out_data[OUT_W-1:$bits(t_result)], '0);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_words.push_back(track_packet(i_in_data[TS_W-1:0],
                                                      i_in_data[IN_W-1:TS_W]));
        end
        o_pending <= expected_words.size();
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the scaled RTP timestamp tracker testbench: clock, reset, packet and
// configuration stimulus, and the verdict. Depends on srtt_pkg, srtt_scoreboard, the RTL.
module tb_top;
    import srtt_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_index;
    logic [STRIDE_W-1:0] i_cfg_data;

    int                  fail_count;
    int                  pending;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    logic [STRIDE_W-1:0] stride_limit  = MAX_STRIDE_RST;
    logic                hold_go       = 1'b0;
    logic                hold_done     = 1'b0;
    int                  hold_left     = 0;

    scaled_rtp_timestamp_tracker_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    srtt_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random back-pressure, plus one long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_left     <= 400;
            hold_done     <= 1'b1;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        #15_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // offer one packet word and wait until it is taken
    task automatic send_packet(input logic [TS_W-1:0] ts, input logic [SN_W-1:0] sn);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sn, ts};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic idx, input logic [STRIDE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain: every result back, then let the block go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (100) @(posedge i_clk);
    endtask

    // mostly steady streams with random content, some losses and glitches, some noise
    task automatic send_stream(input int n_items);
        int              sent;
        int              run_len;
        int              k;
        int              pick;
        int              mult;
        logic [TS_W-1:0] ts;
        logic [TS_W-1:0] step_sz;
        logic [SN_W-1:0] sn;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    step_sz = $urandom_range(1, 2000);
                else if (pick < 8)
                    step_sz = $urandom_range(1, 32'h001F_FFFF);
                else
                    step_sz = $urandom_range(1, 32'h1FFF_FFFF);
                if (step_sz > stride_limit)
                    step_sz = $urandom_range(1, stride_limit);
                ts      = $urandom;
                sn      = SN_W'($urandom);
                run_len = $urandom_range(3, 24);
                for (k = 0; k < run_len; k++) begin
                    pick = $urandom_range(0, 99);
                    if (k == 0) begin
                        // run starts anywhere
                    end else if (pick < 80) begin
                        ts += step_sz;
                        sn += 1;
                    end else if (pick < 88) begin
                        // packet loss
                        mult = $urandom_range(2, 4);
                        ts += mult * step_sz;
                        sn += SN_W'(mult);
                    end else if (pick < 92) begin
                        ts += $urandom_range(2, 4) * step_sz;
                        sn += 1;
                    end else if (pick < 95) begin
                        ts -= step_sz;
                        sn -= 1;
                    end else if (pick < 98) begin
                        ts += step_sz + $urandom_range(1, 7);
                        sn += 1;
                    end
                    send_packet(ts, sn);
                    sent++;
                end
            end else begin
                send_packet($urandom, SN_W'($urandom));
                sent++;
            end
        end
    endtask

    task automatic start_phase(input logic [STRIDE_W-1:0] max_val, input logic [REP_W-1:0] rep_val,
                               input int snd_pct, input int rcv_pct);
        settle();
        write_reg(CFG_MAX_STRIDE, max_val);
        write_reg(CFG_REPEAT_MIN, {{(STRIDE_W-REP_W){1'b0}}, rep_val});
        stride_limit  = max_val;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
    endtask

    initial begin : stimulus
        int k;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_MAX_STRIDE;
        i_cfg_data    = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed packets with the default settings
        start_phase(MAX_STRIDE_RST, REPEAT_MIN_RST, 20, 86);
        send_packet(32'hFFFF_FFFF, 16'hFFFF);     // first packet only stores
        send_packet(32'hFFFF_FFFF, 16'h0000);     // zero delta
        send_packet(32'h0000_0000, 16'h0001);     // delta above the limit
        send_packet(32'h1FFF_FFFF, 16'h0002);     // delta right at the limit
        for (k = 0; k < 6; k++)                   // learn 160, then scaled
            send_packet(32'd1000 + 160 * k, 16'(10 + k));
        send_packet(32'd2120, 16'd17);            // loss of one packet
        send_packet(32'd1960, 16'd16);            // one step back
        send_packet(32'd2440, 16'd17);            // multiple, sequence disagrees
        send_packet(32'd2600, 16'd18);
        send_packet(32'd2760, 16'd19);
        send_packet(32'd2920, 16'd20);
        send_packet(32'd3020, 16'd21);            // not a multiple
        send_packet(32'd3120, 16'd22);
        send_packet(32'd3220, 16'd23);
        send_packet(32'd3320, 16'd24);
        send_packet(32'd3250, 16'd25);            // backwards with a new offset
        send_packet(32'hFFFF_FF00, 16'd26);
        send_packet(32'h0000_0010, 16'd27);       // timestamp wraps
        send_stream(215);

        start_phase(29'd1000, 4'd1, 20, 86);
        send_stream(240);

        start_phase(29'd1, 4'd15, 86, 20);
        send_stream(240);

        start_phase(STRIDE_W'($urandom_range(2, MAX_STRIDE_RST)), 4'd0, 86, 20);
        send_stream(240);

        // no idling; the result side blocks for a long stretch mid-phase
        start_phase(MAX_STRIDE_RST, 4'd15, 0, 0);
        send_stream(30);
        hold_go <= 1'b1;
        send_stream(210);

        start_phase(29'h0010_0000, 4'($urandom_range(1, 15)), 0, 0);
        send_stream(240);

        settle();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
